// ===== src/bilinear_interp_nonuniform_grid_macros.svh =====
// Assertion helpers for the bilinear interpolation block.
`ifndef BILINEAR_INTERP_NONUNIFORM_GRID_MACROS_SVH
`define BILINEAR_INTERP_NONUNIFORM_GRID_MACROS_SVH

// Same-cycle implication, disabled while rstn is low
`define BING_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rstn is low
`define BING_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bing_pkg.sv =====
// ----------------------------------------------------------------------------
// bing_pkg
// Shared constants, codes and types of the bilinear interpolation block.
// ----------------------------------------------------------------------------
package bing_pkg;

    // Grid sizes
    localparam int X_POINTS  = 64;
    localparam int Y_POINTS  = 64;
    localparam int XIW       = $clog2(X_POINTS);
    localparam int YIW       = $clog2(Y_POINTS);
    localparam int SRCH_N    = (X_POINTS > Y_POINTS) ? X_POINTS : Y_POINTS;
    localparam int CNTW      = $clog2(SRCH_N + 1);
    localparam int IMG_DEPTH = X_POINTS * Y_POINTS;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);

    // Command queue
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Fraction format: 0..65536
    localparam int          FRACW    = 17;
    localparam logic [16:0] FRAC_ONE = 17'd65536;

    // Item kinds
    localparam logic [1:0] FUNC_LOAD_X = 2'd0;
    localparam logic [1:0] FUNC_LOAD_Y = 2'd1;
    localparam logic [1:0] FUNC_LOAD_I = 2'd2;
    localparam logic [1:0] FUNC_QUERY  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_CENTER_X = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y = 3'd1;
    localparam logic [2:0] CFG_X_LOW    = 3'd2;
    localparam logic [2:0] CFG_X_HIGH   = 3'd3;
    localparam logic [2:0] CFG_Y_LOW    = 3'd4;
    localparam logic [2:0] CFG_Y_HIGH   = 3'd5;

    // Classified item passed from front to back
    typedef struct packed {
        logic [1:0]         func;
        logic [5:0]         col;
        logic [5:0]         row;
        logic signed [31:0] load_value;
        logic signed [32:0] vx;
        logic signed [32:0] vy;
        logic               in_range;
    } qent_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== src/bing_front.sv =====
// ----------------------------------------------------------------------------
// bing_front
// Configuration registers, item intake, centering and range check.
// ----------------------------------------------------------------------------
module bing_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_func,
    input  logic [5:0]            s_column_index,
    input  logic [5:0]            s_row_index,
    input  logic signed [31:0]    s_load_value,
    input  logic signed [31:0]    s_point_x,
    input  logic signed [31:0]    s_point_y,
    input  bing_pkg::q_stat_t     q_stat,
    output logic                  q_push,
    output bing_pkg::qent_t       q_wdata
);

    logic signed [31:0] cx_reg, cy_reg, xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic signed [32:0] vx, vy;
    logic               x_in, y_in;

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            xlo_reg <= '0;
            xhi_reg <= '0;
            ylo_reg <= '0;
            yhi_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                bing_pkg::CFG_CENTER_X: cx_reg  <= cfg_data;
                bing_pkg::CFG_CENTER_Y: cy_reg  <= cfg_data;
                bing_pkg::CFG_X_LOW:    xlo_reg <= cfg_data;
                bing_pkg::CFG_X_HIGH:   xhi_reg <= cfg_data;
                bing_pkg::CFG_Y_LOW:    ylo_reg <= cfg_data;
                bing_pkg::CFG_Y_HIGH:   yhi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Centering and range check (signed compares)
    always_comb begin
        vx   = {s_point_x[31], s_point_x} - {cx_reg[31], cx_reg};
        vy   = {s_point_y[31], s_point_y} - {cy_reg[31], cy_reg};
        x_in = (vx >= $signed({xlo_reg[31], xlo_reg})) &&
               (vx <= $signed({xhi_reg[31], xhi_reg}));
        y_in = (vy >= $signed({ylo_reg[31], ylo_reg})) &&
               (vy <= $signed({yhi_reg[31], yhi_reg}));
    end

    assign s_ready = !q_stat.full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_wdata.func       = s_func;
        q_wdata.col        = s_column_index;
        q_wdata.row        = s_row_index;
        q_wdata.load_value = s_load_value;
        q_wdata.vx         = vx;
        q_wdata.vy         = vy;
        q_wdata.in_range   = x_in && y_in;
    end

endmodule

// ===== src/bing_queue.sv =====
// ----------------------------------------------------------------------------
// bing_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module bing_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bing_pkg::qent_t   wdata,
    input  logic              pop,
    output bing_pkg::qent_t   rdata,
    output bing_pkg::q_stat_t stat
);

    bing_pkg::qent_t                 mem_reg [bing_pkg::QDEPTH];
    logic [bing_pkg::QPW-1:0]        wp_reg, rp_reg;
    logic [bing_pkg::QCW-1:0]        cnt_reg;

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == bing_pkg::QPW'(bing_pkg::QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == bing_pkg::QPW'(bing_pkg::QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + bing_pkg::QCW'(push) - bing_pkg::QCW'(pop);
        end
    end

    assign rdata      = mem_reg[rp_reg];
    assign stat.full  = (cnt_reg == bing_pkg::QCW'(bing_pkg::QDEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// ===== src/bing_div.sv =====
// ----------------------------------------------------------------------------
// bing_div
// Bit-serial divider for the cell fraction: round(n * 65536 / d), n < d.
// ----------------------------------------------------------------------------
module bing_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [32:0] den,
    output logic        done,
    output logic [16:0] quo
);

    logic [49:0] dividend;
    logic [33:0] rem_reg;
    logic [16:0] sh_reg;
    logic [16:0] q_reg;
    logic [32:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [33:0] rs;
    logic        ge;

    // Numerator with the rounding half added
    assign dividend = {1'b0, num, 16'd0} + 50'(den >> 1);
    assign rs       = {rem_reg[32:0], sh_reg[16]};
    assign ge       = (rs >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 5'd17;
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == 5'd1);
            end
        end
    end

    // Restoring steps, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, dividend[49:17]};
            sh_reg  <= dividend[16:0];
            den_reg <= den;
            q_reg   <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? rs - {1'b0, den_reg} : rs;
            sh_reg  <= {sh_reg[15:0], 1'b0};
            q_reg   <= {q_reg[15:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== src/bing_back.sv =====
// ----------------------------------------------------------------------------
// bing_back
// Table storage, grid search, fraction, interpolation and result register.
// ----------------------------------------------------------------------------
module bing_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  bing_pkg::q_stat_t  q_stat,
    input  bing_pkg::qent_t    q_rdata,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sample_value,
    output logic               m_inside_res
);

    localparam int XIW = bing_pkg::XIW;
    localparam int YIW = bing_pkg::YIW;
    localparam int AW  = bing_pkg::IMG_AW;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SRCH = 5'd1;
    localparam logic [4:0] S_LOC  = 5'd2;
    localparam logic [4:0] S_RG0  = 5'd3;
    localparam logic [4:0] S_RG1  = 5'd4;
    localparam logic [4:0] S_RG2  = 5'd5;
    localparam logic [4:0] S_FX   = 5'd6;
    localparam logic [4:0] S_WX   = 5'd7;
    localparam logic [4:0] S_FY   = 5'd8;
    localparam logic [4:0] S_WY   = 5'd9;
    localparam logic [4:0] S_I0   = 5'd10;
    localparam logic [4:0] S_I1   = 5'd11;
    localparam logic [4:0] S_I2   = 5'd12;
    localparam logic [4:0] S_I3   = 5'd13;
    localparam logic [4:0] S_I4   = 5'd14;
    localparam logic [4:0] S_M0   = 5'd15;
    localparam logic [4:0] S_A0   = 5'd16;
    localparam logic [4:0] S_M1   = 5'd17;
    localparam logic [4:0] S_A1   = 5'd18;
    localparam logic [4:0] S_M2   = 5'd19;
    localparam logic [4:0] S_A2   = 5'd20;
    localparam logic [4:0] S_DONE = 5'd21;

    // Memories
    logic signed [31:0] x_grid [bing_pkg::X_POINTS];
    logic signed [31:0] y_grid [bing_pkg::Y_POINTS];
    logic signed [31:0] image_table [bing_pkg::IMG_DEPTH];
    logic signed [31:0] xg_rd_reg, yg_rd_reg, img_rd_reg;
    logic [XIW-1:0]     xg_raddr;
    logic [YIW-1:0]     yg_raddr;
    logic [AW-1:0]      img_raddr;

    logic [4:0]              state_reg;
    logic signed [32:0]      vx_reg, vy_reg;
    logic [bing_pkg::CNTW-1:0] cnt_reg;
    logic [33:0]             bdx_reg, bdy_reg;
    logic [XIW-1:0]          bix_reg, ix_reg;
    logic [YIW-1:0]          biy_reg, iy_reg;
    logic signed [31:0]      bgx_reg, bgy_reg;
    logic signed [31:0]      gx0_reg, gx1_reg, gy0_reg, gy1_reg;
    logic [16:0]             fx_reg, fy_reg;
    logic signed [31:0]      c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [31:0]      la_reg, lb_reg;
    logic signed [50:0]      t_reg;
    logic                    ov_reg;
    logic signed [31:0]      res_reg;
    logic                    ins_reg;
    logic signed [31:0]      out_val_reg;
    logic                    out_ins_reg, out_vld_reg;

    // Search compare
    logic [bing_pkg::CNTW-1:0] sidx;
    logic signed [33:0]      dx_diff, dy_diff;
    logic [33:0]             dx_mag, dy_mag;

    // Locate results
    logic              x_out, y_out;
    logic [XIW-1:0]    ix_loc;
    logic [YIW-1:0]    iy_loc;

    // Fraction operands
    logic signed [33:0] fn;
    logic signed [32:0] fd;
    logic               f_zero, f_one;
    logic               div_start, div_done;
    logic [16:0]        div_quo;

    // Multiplier and rounding
    logic signed [32:0] mul_a;
    logic [16:0]        mul_f;
    logic signed [50:0] prod;
    logic signed [50:0] rmag;
    logic signed [34:0] rnd;
    logic signed [35:0] lsum;
    logic signed [31:0] sat;

    // Memory writes and registered reads
    always_ff @(posedge aclk) begin
        if (q_pop && q_rdata.func == bing_pkg::FUNC_LOAD_X &&
            32'(q_rdata.col) < bing_pkg::X_POINTS) begin
            x_grid[XIW'(q_rdata.col)] <= q_rdata.load_value;
        end
        xg_rd_reg <= x_grid[xg_raddr];
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_rdata.func == bing_pkg::FUNC_LOAD_Y &&
            32'(q_rdata.col) < bing_pkg::Y_POINTS) begin
            y_grid[YIW'(q_rdata.col)] <= q_rdata.load_value;
        end
        yg_rd_reg <= y_grid[yg_raddr];
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_rdata.func == bing_pkg::FUNC_LOAD_I &&
            32'(q_rdata.col) < bing_pkg::X_POINTS &&
            32'(q_rdata.row) < bing_pkg::Y_POINTS) begin
            image_table[AW'(AW'(q_rdata.row) * AW'(bing_pkg::X_POINTS)) + AW'(q_rdata.col)]
                <= q_rdata.load_value;
        end
        img_rd_reg <= image_table[img_raddr];
    end

    // Read address selection
    always_comb begin
        case (state_reg)
            S_SRCH:  xg_raddr = XIW'(cnt_reg);
            S_RG1:   xg_raddr = ix_reg + 1'b1;
            default: xg_raddr = ix_reg;
        endcase
        case (state_reg)
            S_SRCH:  yg_raddr = YIW'(cnt_reg);
            S_RG1:   yg_raddr = iy_reg + 1'b1;
            default: yg_raddr = iy_reg;
        endcase
        case (state_reg)
            S_I1:    img_raddr = AW'(AW'(iy_reg) * AW'(bing_pkg::X_POINTS)) + AW'(ix_reg + 1'b1);
            S_I2:    img_raddr = AW'(AW'(iy_reg + 1'b1) * AW'(bing_pkg::X_POINTS))
                                 + AW'(ix_reg);
            S_I3:    img_raddr = AW'(AW'(iy_reg + 1'b1) * AW'(bing_pkg::X_POINTS))
                                 + AW'(ix_reg + 1'b1);
            default: img_raddr = AW'(AW'(iy_reg) * AW'(bing_pkg::X_POINTS)) + AW'(ix_reg);
        endcase
    end

    // Distance of the returning grid entry
    always_comb begin
        sidx    = cnt_reg - 1'b1;
        dx_diff = {vx_reg[32], vx_reg} - {{2{xg_rd_reg[31]}}, xg_rd_reg};
        dy_diff = {vy_reg[32], vy_reg} - {{2{yg_rd_reg[31]}}, yg_rd_reg};
        dx_mag  = dx_diff[33] ? 34'(-dx_diff) : 34'(dx_diff);
        dy_mag  = dy_diff[33] ? 34'(-dy_diff) : 34'(dy_diff);
    end

    // Cell from nearest entry: step back when below, last entry uses last cell
    always_comb begin
        x_out  = 1'b0;
        ix_loc = bix_reg;
        if (vx_reg < $signed({bgx_reg[31], bgx_reg})) begin
            if (bix_reg == '0) x_out = 1'b1;
            else               ix_loc = bix_reg - 1'b1;
        end else if (bix_reg == XIW'(bing_pkg::X_POINTS - 1)) begin
            if (vx_reg == {bgx_reg[31], bgx_reg}) ix_loc = XIW'(bing_pkg::X_POINTS - 2);
            else                                  x_out  = 1'b1;
        end
        y_out  = 1'b0;
        iy_loc = biy_reg;
        if (vy_reg < $signed({bgy_reg[31], bgy_reg})) begin
            if (biy_reg == '0) y_out = 1'b1;
            else               iy_loc = biy_reg - 1'b1;
        end else if (biy_reg == YIW'(bing_pkg::Y_POINTS - 1)) begin
            if (vy_reg == {bgy_reg[31], bgy_reg}) iy_loc = YIW'(bing_pkg::Y_POINTS - 2);
            else                                  y_out  = 1'b1;
        end
    end

    // Fraction operands for the axis in work
    always_comb begin
        if (state_reg == S_FY) begin
            fn = {vy_reg[32], vy_reg} - {{2{gy0_reg[31]}}, gy0_reg};
            fd = {gy1_reg[31], gy1_reg} - {gy0_reg[31], gy0_reg};
        end else begin
            fn = {vx_reg[32], vx_reg} - {{2{gx0_reg[31]}}, gx0_reg};
            fd = {gx1_reg[31], gx1_reg} - {gx0_reg[31], gx0_reg};
        end
        f_zero    = (fd <= 0) || (fn <= 0);
        f_one     = !f_zero && (fn >= {fd[32], fd});
        div_start = (state_reg == S_FX || state_reg == S_FY) && !f_zero && !f_one;
    end

    bing_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (fn[32:0]),
        .den     (fd),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Shared multiplier, rounding and saturation
    always_comb begin
        case (state_reg)
            S_M1: begin
                mul_a = {c11_reg[31], c11_reg} - {c10_reg[31], c10_reg};
                mul_f = fx_reg;
            end
            S_M2: begin
                mul_a = {lb_reg[31], lb_reg} - {la_reg[31], la_reg};
                mul_f = fy_reg;
            end
            default: begin
                mul_a = {c01_reg[31], c01_reg} - {c00_reg[31], c00_reg};
                mul_f = fx_reg;
            end
        endcase
        prod = 51'(mul_a * $signed({1'b0, mul_f}));
        rmag = (t_reg[50] ? -t_reg : t_reg) + 51'sd32768;
        rnd  = t_reg[50] ? -$signed(rmag[50:16]) : $signed(rmag[50:16]);
        case (state_reg)
            S_A0:    lsum = 36'(c00_reg) + 36'(rnd);
            S_A1:    lsum = 36'(c10_reg) + 36'(rnd);
            default: lsum = 36'(la_reg) + 36'(rnd);
        endcase
        if (lsum > 36'sd2147483647)        sat = 32'sh7fffffff;
        else if (lsum < -36'sd2147483648)  sat = 32'sh80000000;
        else                               sat = lsum[31:0];
    end

    assign q_pop = (state_reg == S_IDLE) && !q_stat.empty;

    // Sequencer: control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    cnt_reg <= '0;
                    if (q_pop && q_rdata.func == bing_pkg::FUNC_QUERY) begin
                        state_reg <= q_rdata.in_range ? S_SRCH : S_DONE;
                    end
                end
                S_SRCH: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == bing_pkg::CNTW'(bing_pkg::SRCH_N)) state_reg <= S_LOC;
                end
                S_LOC:   state_reg <= (x_out || y_out) ? S_DONE : S_RG0;
                S_RG0:   state_reg <= S_RG1;
                S_RG1:   state_reg <= S_RG2;
                S_RG2:   state_reg <= S_FX;
                S_FX:    state_reg <= div_start ? S_WX : S_FY;
                S_WX:    if (div_done) state_reg <= S_FY;
                S_FY:    state_reg <= div_start ? S_WY : S_I0;
                S_WY:    if (div_done) state_reg <= S_I0;
                S_I0:    state_reg <= S_I1;
                S_I1:    state_reg <= S_I2;
                S_I2:    state_reg <= S_I3;
                S_I3:    state_reg <= S_I4;
                S_I4:    state_reg <= S_M0;
                S_M0:    state_reg <= S_A0;
                S_A0:    state_reg <= S_M1;
                S_M1:    state_reg <= S_A1;
                S_A1:    state_reg <= S_M2;
                S_M2:    state_reg <= S_A2;
                S_A2:    state_reg <= S_DONE;
                S_DONE:  if (!out_vld_reg || m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Sequencer: datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                vx_reg  <= q_rdata.vx;
                vy_reg  <= q_rdata.vy;
                res_reg <= '0;
                ins_reg <= 1'b0;
            end
            S_SRCH: begin
                if (cnt_reg != '0 && 32'(sidx) < bing_pkg::X_POINTS &&
                    (sidx == '0 || dx_mag < bdx_reg)) begin
                    bdx_reg <= dx_mag;
                    bix_reg <= XIW'(sidx);
                    bgx_reg <= xg_rd_reg;
                end
                if (cnt_reg != '0 && 32'(sidx) < bing_pkg::Y_POINTS &&
                    (sidx == '0 || dy_mag < bdy_reg)) begin
                    bdy_reg <= dy_mag;
                    biy_reg <= YIW'(sidx);
                    bgy_reg <= yg_rd_reg;
                end
            end
            S_LOC: begin
                ix_reg <= ix_loc;
                iy_reg <= iy_loc;
            end
            S_RG1: begin
                gx0_reg <= xg_rd_reg;
                gy0_reg <= yg_rd_reg;
            end
            S_RG2: begin
                gx1_reg <= xg_rd_reg;
                gy1_reg <= yg_rd_reg;
            end
            S_FX: fx_reg <= f_one ? bing_pkg::FRAC_ONE : '0;
            S_WX: if (div_done) fx_reg <= div_quo;
            S_FY: fy_reg <= f_one ? bing_pkg::FRAC_ONE : '0;
            S_WY: if (div_done) fy_reg <= div_quo;
            S_I1: c00_reg <= img_rd_reg;
            S_I2: c01_reg <= img_rd_reg;
            S_I3: c10_reg <= img_rd_reg;
            S_I4: c11_reg <= img_rd_reg;
            S_M0, S_M1, S_M2: t_reg <= prod;
            S_A0: la_reg <= sat;
            S_A1: lb_reg <= sat;
            S_A2: begin
                res_reg <= sat;
                ins_reg <= 1'b1;
            end
            default: ;
        endcase
        ov_reg <= 1'b0;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (state_reg == S_DONE && (!out_vld_reg || m_ready)) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!out_vld_reg || m_ready)) begin
            out_val_reg <= res_reg;
            out_ins_reg <= ins_reg;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_sample_value = ov_reg ? '0 : out_val_reg;
    assign m_inside_res   = out_ins_reg;

endmodule

// ===== src/bilinear_interp_nonuniform_grid.sv =====
// ----------------------------------------------------------------------------
// bilinear_interp_nonuniform_grid
// Bilinear interpolation over a rectilinear grid with uneven spacing.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one item per transfer. Kinds 0/1/2 write an x-grid entry,
//   a y-grid entry or an image sample and return nothing. Kind 3 queries a
//   point and returns one m_* transfer (sample_value, inside_res).
//   cfg_* channel: register writes (centers, ranges), always ready; write
//   only while the block has no work in flight.
//   Flow: a load retires from the queue while the back end stays idle.
//   A query runs a grid search (one entry per cycle from each grid memory),
//   the bit-serial fraction divider per axis when the fraction lies strictly
//   between 0 and 1, 4 image memory reads and the shared multiplier. Outside
//   points skip all steps after the search; out-of-range points skip the
//   search too. A 4-deep queue takes items while a query runs.
//   Reset clears control state and config registers; tables are undefined
//   until written. When m_ready is low the result holds in its output
//   register and the back end waits; the queue keeps taking items until full.
// ----------------------------------------------------------------------------
module bilinear_interp_nonuniform_grid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [5:0]         s_column_index,
    input  logic [5:0]         s_row_index,
    input  logic signed [31:0] s_load_value,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_sample_value,
    output logic               m_inside_res
);

    bing_pkg::q_stat_t q_stat;
    bing_pkg::qent_t   q_wdata, q_rdata;
    logic              q_push, q_pop;

    bing_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_column_index (s_column_index),
        .s_row_index    (s_row_index),
        .s_load_value   (s_load_value),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .q_stat         (q_stat),
        .q_push         (q_push),
        .q_wdata        (q_wdata)
    );

    bing_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    bing_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value),
        .m_inside_res   (m_inside_res)
    );

endmodule

// ===== src/bing_chk.sv =====
// ----------------------------------------------------------------------------
// bing_chk
// Port-level checks of the bilinear interpolation block.
// ----------------------------------------------------------------------------
`include "bilinear_interp_nonuniform_grid_macros.svh"

module bing_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_sample_value,
    input logic               m_inside_res
);

    // Outside points report zero
    `BING_ASSERT_IMP(a_outside_zero, aclk, aresetn, m_valid && !m_inside_res, m_sample_value == 32'sd0, "outside result is not zero")

    // A stalled result holds
    `BING_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_value) && $stable(m_inside_res), "stalled result changed")

    // Reset empties the result register
    `BING_ASSERT_NXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid, "result valid after reset")

endmodule

bind bilinear_interp_nonuniform_grid bing_chk u_chk (.*);
